// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the segment/triangle test RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define SVA_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is held
`define SVA_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hdl/sti_pkg.sv -----
// ---------------------------------------------------------------------------
// sti_pkg
// Shared types and constants for the segment/triangle crossing test.
// ---------------------------------------------------------------------------
package sti_pkg;

    // Width of one packed vector field
    localparam int VEC_WIDTH = 48;

    // Default coordinate lane width
    localparam int COORD_WIDTH_DEF = 16;

    // One input item: motion segment plus triangle
    typedef struct packed {
        logic [VEC_WIDTH-1:0] cur_pos;
        logic [VEC_WIDTH-1:0] old_pos;
        logic [VEC_WIDTH-1:0] vertex_a;
        logic [VEC_WIDTH-1:0] vertex_b;
        logic [VEC_WIDTH-1:0] vertex_c;
    } t_sti_in;

    // One result item
    typedef struct packed {
        logic hit;
        logic degenerate;
    } t_sti_out;

endpackage

// ----- hdl/sti_edge_stage.sv -----
// ---------------------------------------------------------------------------
// sti_edge_stage
// Unpacks the coordinate lanes and registers the edge vectors u, v, w, d.
// ---------------------------------------------------------------------------
module sti_edge_stage
    import sti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  t_sti_in                       i_item,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH:0]   o_u [3],
    output logic signed [COORD_WIDTH:0]   o_v [3],
    output logic signed [COORD_WIDTH:0]   o_w [3],
    output logic signed [COORD_WIDTH:0]   o_d [3]
);

    localparam int CW  = COORD_WIDTH;
    localparam int CW1 = COORD_WIDTH + 1;
    localparam int EXW = VEC_WIDTH + 3 * COORD_WIDTH;

    // Zero-extend each field so lanes past the top read as zero
    logic [EXW-1:0] ext_p, ext_q, ext_a0, ext_a1, ext_a2;

    assign ext_p  = {(3 * CW)'(0), i_item.cur_pos};
    assign ext_q  = {(3 * CW)'(0), i_item.old_pos};
    assign ext_a0 = {(3 * CW)'(0), i_item.vertex_a};
    assign ext_a1 = {(3 * CW)'(0), i_item.vertex_b};
    assign ext_a2 = {(3 * CW)'(0), i_item.vertex_c};

    logic signed [CW-1:0] p [3], q [3], a0 [3], a1 [3], a2 [3];
    logic signed [CW:0]   n_u [3], n_v [3], n_w [3], n_d [3];
    logic signed [CW:0]   r_u [3], r_v [3], r_w [3], r_d [3];
    logic                 r_valid;

    // Take lanes apart and form the edge differences
    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign p[k]  = $signed(ext_p[k*CW +: CW]);
        assign q[k]  = $signed(ext_q[k*CW +: CW]);
        assign a0[k] = $signed(ext_a0[k*CW +: CW]);
        assign a1[k] = $signed(ext_a1[k*CW +: CW]);
        assign a2[k] = $signed(ext_a2[k*CW +: CW]);

        assign n_u[k] = CW1'(a0[k]) - CW1'(a1[k]);
        assign n_v[k] = CW1'(a0[k]) - CW1'(a2[k]);
        assign n_w[k] = CW1'(p[k])  - CW1'(a0[k]);
        assign n_d[k] = CW1'(q[k])  - CW1'(p[k]);
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Hold the edge vectors
    always_ff @(posedge i_clk) begin
        r_u <= n_u;
        r_v <= n_v;
        r_w <= n_w;
        r_d <= n_d;
    end

    assign o_valid = r_valid;
    assign o_u     = r_u;
    assign o_v     = r_v;
    assign o_w     = r_w;
    assign o_d     = r_d;

endmodule

// ----- hdl/sti_cross_stage.sv -----
// ---------------------------------------------------------------------------
// sti_cross_stage
// Registers the cross products u x v, w x v and u x w, and carries w and d.
// ---------------------------------------------------------------------------
module sti_cross_stage
    import sti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [COORD_WIDTH:0]       i_u [3],
    input  logic signed [COORD_WIDTH:0]       i_v [3],
    input  logic signed [COORD_WIDTH:0]       i_w [3],
    input  logic signed [COORD_WIDTH:0]       i_d [3],
    output logic                              o_valid,
    output logic signed [2*COORD_WIDTH+2:0]   o_uv [3],
    output logic signed [2*COORD_WIDTH+2:0]   o_wv [3],
    output logic signed [2*COORD_WIDTH+2:0]   o_uw [3],
    output logic signed [COORD_WIDTH:0]       o_w [3],
    output logic signed [COORD_WIDTH:0]       o_d [3]
);

    localparam int MW = 2 * COORD_WIDTH + 2;
    localparam int PW = 2 * COORD_WIDTH + 3;

    logic signed [MW-1:0] m_uv_a [3], m_uv_b [3];
    logic signed [MW-1:0] m_wv_a [3], m_wv_b [3];
    logic signed [MW-1:0] m_uw_a [3], m_uw_b [3];
    logic signed [PW-1:0] n_uv [3], n_wv [3], n_uw [3];
    logic signed [PW-1:0] r_uv [3], r_wv [3], r_uw [3];
    logic signed [COORD_WIDTH:0] r_w [3], r_d [3];
    logic r_valid;

    // Form each cross-product component from its two lane products
    for (genvar k = 0; k < 3; k++) begin : g_cross
        localparam int J1 = (k + 1) % 3;
        localparam int J2 = (k + 2) % 3;

        assign m_uv_a[k] = i_u[J1] * i_v[J2];
        assign m_uv_b[k] = i_u[J2] * i_v[J1];
        assign m_wv_a[k] = i_w[J1] * i_v[J2];
        assign m_wv_b[k] = i_w[J2] * i_v[J1];
        assign m_uw_a[k] = i_u[J1] * i_w[J2];
        assign m_uw_b[k] = i_u[J2] * i_w[J1];

        assign n_uv[k] = PW'(m_uv_a[k]) - PW'(m_uv_b[k]);
        assign n_wv[k] = PW'(m_wv_a[k]) - PW'(m_wv_b[k]);
        assign n_uw[k] = PW'(m_uw_a[k]) - PW'(m_uw_b[k]);
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Hold the cross products and carry w and d along
    always_ff @(posedge i_clk) begin
        r_uv <= n_uv;
        r_wv <= n_wv;
        r_uw <= n_uw;
        r_w  <= i_w;
        r_d  <= i_d;
    end

    assign o_valid = r_valid;
    assign o_uv    = r_uv;
    assign o_wv    = r_wv;
    assign o_uw    = r_uw;
    assign o_w     = r_w;
    assign o_d     = r_d;

endmodule

// ----- hdl/sti_dot_stage.sv -----
// ---------------------------------------------------------------------------
// sti_dot_stage
// Two stages: registered lane products, then the summed numerators and
// denominator D = -(uxv).d, Na = -(wxv).d, Nb = -(uxw).d, Nt = (uxv).w.
// ---------------------------------------------------------------------------
module sti_dot_stage
    import sti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [2*COORD_WIDTH+2:0]   i_uv [3],
    input  logic signed [2*COORD_WIDTH+2:0]   i_wv [3],
    input  logic signed [2*COORD_WIDTH+2:0]   i_uw [3],
    input  logic signed [COORD_WIDTH:0]       i_w [3],
    input  logic signed [COORD_WIDTH:0]       i_d [3],
    output logic                              o_valid,
    output logic signed [3*COORD_WIDTH+5:0]   o_den,
    output logic signed [3*COORD_WIDTH+5:0]   o_na,
    output logic signed [3*COORD_WIDTH+5:0]   o_nb,
    output logic signed [3*COORD_WIDTH+5:0]   o_nt
);

    localparam int PRW = 3 * COORD_WIDTH + 4;
    localparam int DW  = 3 * COORD_WIDTH + 6;

    logic signed [PRW-1:0] n_pd [3], n_pa [3], n_pb [3], n_pt [3];
    logic signed [PRW-1:0] r_pd [3], r_pa [3], r_pb [3], r_pt [3];
    logic signed [DW-1:0]  n_den, n_na, n_nb, n_nt;
    logic signed [DW-1:0]  r_den, r_na, r_nb, r_nt;
    logic                  r_valid_p, r_valid_s;

    // Multiply lane by lane
    for (genvar k = 0; k < 3; k++) begin : g_prod
        assign n_pd[k] = i_uv[k] * i_d[k];
        assign n_pa[k] = i_wv[k] * i_d[k];
        assign n_pb[k] = i_uw[k] * i_d[k];
        assign n_pt[k] = i_uv[k] * i_w[k];
    end

    // Sum the lanes; the three d-based sums are negated
    assign n_den = DW'(0) - DW'(r_pd[0]) - DW'(r_pd[1]) - DW'(r_pd[2]);
    assign n_na  = DW'(0) - DW'(r_pa[0]) - DW'(r_pa[1]) - DW'(r_pa[2]);
    assign n_nb  = DW'(0) - DW'(r_pb[0]) - DW'(r_pb[1]) - DW'(r_pb[2]);
    assign n_nt  = DW'(r_pt[0]) + DW'(r_pt[1]) + DW'(r_pt[2]);

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_p <= 1'b0;
            r_valid_s <= 1'b0;
        end else begin
            r_valid_p <= i_valid;
            r_valid_s <= r_valid_p;
        end
    end

    // Hold products, then sums
    always_ff @(posedge i_clk) begin
        r_pd  <= n_pd;
        r_pa  <= n_pa;
        r_pb  <= n_pb;
        r_pt  <= n_pt;
        r_den <= n_den;
        r_na  <= n_na;
        r_nb  <= n_nb;
        r_nt  <= n_nt;
    end

    assign o_valid = r_valid_s;
    assign o_den   = r_den;
    assign o_na    = r_na;
    assign o_nb    = r_nb;
    assign o_nt    = r_nt;

endmodule

// ----- hdl/sti_decide_stage.sv -----
// ---------------------------------------------------------------------------
// sti_decide_stage
// Two stages: fold the sign of D into all terms, then make the exact
// integer range tests and register the result item.
// ---------------------------------------------------------------------------
module sti_decide_stage
    import sti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [3*COORD_WIDTH+5:0]   i_den,
    input  logic signed [3*COORD_WIDTH+5:0]   i_na,
    input  logic signed [3*COORD_WIDTH+5:0]   i_nb,
    input  logic signed [3*COORD_WIDTH+5:0]   i_nt,
    output logic                              o_valid,
    output t_sti_out                          o_result
);

`include "assert_macros.svh"

    localparam int NW = 3 * COORD_WIDTH + 8;

    logic signed [NW-1:0] x_den, x_na, x_nb, x_nt;
    logic signed [NW-1:0] n_den, n_na, n_nb, n_nt;
    logic signed [NW-1:0] r_den, r_na, r_nb, r_nt;
    logic                 n_zero, r_zero, r_valid_n;
    logic signed [NW-1:0] sum_ab, slack_ab, slack_t;
    logic                 in_range;
    t_sti_out             n_result, r_result;
    logic                 r_valid_o;

    // Widen and flip every term when D is negative
    assign x_den = NW'(i_den);
    assign x_na  = NW'(i_na);
    assign x_nb  = NW'(i_nb);
    assign x_nt  = NW'(i_nt);

    assign n_zero = (i_den == '0);
    assign n_den  = i_den[$bits(i_den)-1] ? -x_den : x_den;
    assign n_na   = i_den[$bits(i_den)-1] ? -x_na  : x_na;
    assign n_nb   = i_den[$bits(i_den)-1] ? -x_nb  : x_nb;
    assign n_nt   = i_den[$bits(i_den)-1] ? -x_nt  : x_nt;

    // Test Na >= 0, Nb >= 0, Na + Nb <= D and 0 <= Nt < D
    assign sum_ab   = r_na + r_nb;
    assign slack_ab = r_den - sum_ab;
    assign slack_t  = r_nt - r_den;
    assign in_range = !r_na[NW-1] && !r_nb[NW-1] && !slack_ab[NW-1]
                      && !r_nt[NW-1] && slack_t[NW-1];

    always_comb begin
        n_result.hit        = !r_zero && in_range;
        n_result.degenerate = r_zero;
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_n <= 1'b0;
            r_valid_o <= 1'b0;
        end else begin
            r_valid_n <= i_valid;
            r_valid_o <= r_valid_n;
        end
    end

    // Hold normalised terms, then the result item
    always_ff @(posedge i_clk) begin
        r_den    <= n_den;
        r_na     <= n_na;
        r_nb     <= n_nb;
        r_nt     <= n_nt;
        r_zero   <= n_zero;
        r_result <= n_result;
    end

    assign o_valid  = r_valid_o;
    assign o_result = r_result;

    // A non-degenerate item must leave normalisation with a positive D
    `SVA_IMPLY(a_den_positive, i_clk, i_rst_n, r_valid_n && !r_zero, !r_den[NW-1] && r_den != '0)
    // A normalised item always reaches the output register next
    `SVA_NEXT(a_result_follows, i_clk, i_rst_n, r_valid_n, r_valid_o)

endmodule

// ----- hdl/segment_triangle_intersect.sv -----
// ---------------------------------------------------------------------------
// segment_triangle_intersect
// Pipeline: an accepted item passes six register stages, in the edge, cross,
//   dot and decide stages, before its result strobe rises.
// Throughput: one item per cycle; busy is never raised, as every stage of
//   the multiply/add pipeline advances each cycle and the receiver cannot stall.
// Reset: synchronous, active low; clears the stage valid bits only, so no
//   result strobes after reset until a new item is accepted.
// ---------------------------------------------------------------------------
module segment_triangle_intersect
    import sti_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_sti_in  i_item,
    output logic     busy,
    output logic     o_strobe,
    output t_sti_out o_result
);

`include "assert_macros.svh"

    localparam int PW = 2 * COORD_WIDTH + 3;
    localparam int DW = 3 * COORD_WIDTH + 6;

    logic                        accept;
    logic                        e_valid, c_valid, t_valid;
    logic signed [COORD_WIDTH:0] e_u [3], e_v [3], e_w [3], e_d [3];
    logic signed [COORD_WIDTH:0] c_w [3], c_d [3];
    logic signed [PW-1:0]        c_uv [3], c_wv [3], c_uw [3];
    logic signed [DW-1:0]        t_den, t_na, t_nb, t_nt;

    // Take an item on every start; the pipeline never holds off
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Edge vectors
    sti_edge_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .o_valid (e_valid),
        .o_u     (e_u),
        .o_v     (e_v),
        .o_w     (e_w),
        .o_d     (e_d)
    );

    // Cross products
    sti_cross_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (e_valid),
        .i_u     (e_u),
        .i_v     (e_v),
        .i_w     (e_w),
        .i_d     (e_d),
        .o_valid (c_valid),
        .o_uv    (c_uv),
        .o_wv    (c_wv),
        .o_uw    (c_uw),
        .o_w     (c_w),
        .o_d     (c_d)
    );

    // Dot products into numerators and denominator
    sti_dot_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid),
        .i_uv    (c_uv),
        .i_wv    (c_wv),
        .i_uw    (c_uw),
        .i_w     (c_w),
        .i_d     (c_d),
        .o_valid (t_valid),
        .o_den   (t_den),
        .o_na    (t_na),
        .o_nb    (t_nb),
        .o_nt    (t_nt)
    );

    // Sign fold and range tests
    sti_decide_stage #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (t_valid),
        .i_den    (t_den),
        .i_na     (t_na),
        .i_nb     (t_nb),
        .i_nt     (t_nt),
        .o_valid  (o_strobe),
        .o_result (o_result)
    );

    // Every strobe answers an item that was accepted on start
    `SVA_IMPLY(a_strobe_has_item, i_clk, i_rst_n, o_strobe, $past(start, 6))
    // A flat or parallel case never reports a crossing
    `SVA_IMPLY(a_degenerate_no_hit, i_clk, i_rst_n, o_strobe && o_result.degenerate, !o_result.hit)

endmodule
